/* sv/mrstq_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI running-status transmit queue: shared package
// Sequencer states, ring control bundle and fixed field widths.
// ----------------------------------------------------------------------------
package mrstq_pkg;

    // Field widths fixed by the MIDI and USB-MIDI formats.
    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 3 * BYTE_W;

    // Cable number carried in the high nibble of the USB-MIDI header.
    localparam logic [3:0] CABLE_NUMBER = 4'h0;

    // Operation codes of an input beat.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ_STATUS,
        ST_ENQ_DATA1,
        ST_ENQ_DATA2,
        ST_SVC_FETCH,
        ST_SVC_REPLY
    } state_t;

    // Control bundle from the sequencer to one ring.
    typedef struct packed {
        logic push;   // write the entry at the write index and advance it
        logic fetch;  // read the entry at the read index into the data register
        logic pop;    // advance the read index
    } ring_ctrl_t;

endpackage

/* sv/midi_running_status_tx_queue_unit.sv */
// ----------------------------------------------------------------------------
// MIDI running-status transmit queue
// Event ring feeding USB-MIDI packets and a serial byte ring that leaves out
// a status byte equal to the last status queued.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  command   start, busy          operation, status_byte, first_data,
//                                 second_data, usb_ready, uart_ready
//  result    done (one cycle)     usb_valid, usb_header, usb_status,
//                                 usb_data_one, usb_data_two, serial_valid,
//                                 serial_byte
//
// An enqueue beat has one state per byte through the single write port of
// the byte memory, the status byte being written only when it changes. A
// service beat has a fetch state and a state that returns the registered
// memory data. done is high in the cycle after the last one, when busy is
// already low and a new command may be taken. Reset clears the indices and
// the last status, not the memories. The receiver cannot stall a result.
// ----------------------------------------------------------------------------
module midi_running_status_tx_queue_unit #(
    parameter int EVENT_DEPTH = 8,
    parameter int BYTE_DEPTH  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       operation,
    input  logic [7:0] status_byte,
    input  logic [7:0] first_data,
    input  logic [7:0] second_data,
    input  logic       usb_ready,
    input  logic       uart_ready,
    output logic       done,
    output logic       usb_valid,
    output logic [7:0] usb_header,
    output logic [7:0] usb_status,
    output logic [7:0] usb_data_one,
    output logic [7:0] usb_data_two,
    output logic       serial_valid,
    output logic [7:0] serial_byte
);

    localparam int BW = mrstq_pkg::BYTE_W;
    localparam int EW = mrstq_pkg::EVENT_W;

    mrstq_pkg::state_t     state_reg;
    mrstq_pkg::state_t     state_next;
    mrstq_pkg::ring_ctrl_t ev_ctrl;
    mrstq_pkg::ring_ctrl_t by_ctrl;

    logic [EW-1:0] ev_rd_data;
    logic          ev_not_empty;
    logic [BW-1:0] by_wr_data;
    logic [BW-1:0] by_rd_data;
    logic          by_not_empty;

    // Command beat held for the length of its work.
    logic [BW-1:0] st_reg;
    logic [BW-1:0] d1_reg;
    logic [BW-1:0] d2_reg;
    logic          usb_ok_reg;
    logic          uart_ok_reg;

    logic [BW-1:0] last_status_reg;
    logic [BW-1:0] last_status_next;

    // Result registers.
    logic          done_reg;
    logic          done_next;
    logic          usb_valid_reg;
    logic          usb_valid_next;
    logic [BW-1:0] usb_header_reg;
    logic [BW-1:0] usb_header_next;
    logic [BW-1:0] usb_status_reg;
    logic [BW-1:0] usb_status_next;
    logic [BW-1:0] usb_d1_reg;
    logic [BW-1:0] usb_d1_next;
    logic [BW-1:0] usb_d2_reg;
    logic [BW-1:0] usb_d2_next;
    logic          serial_valid_reg;
    logic          serial_valid_next;
    logic [BW-1:0] serial_byte_reg;
    logic [BW-1:0] serial_byte_next;

    logic          accept;
    logic          ev_go;
    logic          by_go;

    assign accept = start && (state_reg == mrstq_pkg::ST_IDLE);
    assign ev_go  = usb_ok_reg && ev_not_empty;
    assign by_go  = usb_ok_reg && uart_ok_reg && by_not_empty;

    // Event ring: whole events for USB-MIDI packets.
    mrstq_ring #(
        .WIDTH (EW),
        .DEPTH (EVENT_DEPTH)
    ) u_event_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ev_ctrl),
        .wr_data   ({st_reg, d1_reg, d2_reg}),
        .rd_data   (ev_rd_data),
        .not_empty (ev_not_empty)
    );

    // Byte ring: bytes for the serial MIDI line.
    mrstq_ring #(
        .WIDTH (BW),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (by_ctrl),
        .wr_data   (by_wr_data),
        .rd_data   (by_rd_data),
        .not_empty (by_not_empty)
    );

    // Sequencer: next state, ring control and result values.
    always_comb
    begin
        state_next        = state_reg;
        ev_ctrl           = '0;
        by_ctrl           = '0;
        by_wr_data        = st_reg;
        last_status_next  = last_status_reg;
        done_next         = 1'b0;
        usb_valid_next    = 1'b0;
        usb_header_next   = '0;
        usb_status_next   = '0;
        usb_d1_next       = '0;
        usb_d2_next       = '0;
        serial_valid_next = 1'b0;
        serial_byte_next  = '0;

        unique case (state_reg)
            mrstq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (operation == mrstq_pkg::OP_ENQUEUE) ?
                                 mrstq_pkg::ST_ENQ_STATUS : mrstq_pkg::ST_SVC_FETCH;
                end
            end
            mrstq_pkg::ST_ENQ_STATUS:
            begin
                // Event goes in whole; the status byte only when it changes.
                ev_ctrl.push = 1'b1;
                if (st_reg != last_status_reg)
                begin
                    by_ctrl.push     = 1'b1;
                    last_status_next = st_reg;
                end
                state_next = mrstq_pkg::ST_ENQ_DATA1;
            end
            mrstq_pkg::ST_ENQ_DATA1:
            begin
                by_ctrl.push = 1'b1;
                by_wr_data   = d1_reg;
                state_next   = mrstq_pkg::ST_ENQ_DATA2;
            end
            mrstq_pkg::ST_ENQ_DATA2:
            begin
                // An enqueue result is all zero.
                by_ctrl.push = 1'b1;
                by_wr_data   = d2_reg;
                done_next    = 1'b1;
                state_next   = mrstq_pkg::ST_IDLE;
            end
            mrstq_pkg::ST_SVC_FETCH:
            begin
                ev_ctrl.fetch = 1'b1;
                by_ctrl.fetch = 1'b1;
                state_next    = mrstq_pkg::ST_SVC_REPLY;
            end
            mrstq_pkg::ST_SVC_REPLY:
            begin
                // Memory data is valid now; indices have not moved since fetch.
                done_next = 1'b1;
                if (ev_go)
                begin
                    ev_ctrl.pop     = 1'b1;
                    usb_valid_next  = 1'b1;
                    usb_header_next = {mrstq_pkg::CABLE_NUMBER, ev_rd_data[EW-1 -: 4]};
                    usb_status_next = ev_rd_data[EW-1 -: BW];
                    usb_d1_next     = ev_rd_data[2*BW-1 -: BW];
                    usb_d2_next     = ev_rd_data[BW-1:0];
                end
                if (by_go)
                begin
                    by_ctrl.pop       = 1'b1;
                    serial_valid_next = 1'b1;
                    serial_byte_next  = by_rd_data;
                end
                state_next = mrstq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mrstq_pkg::ST_IDLE;
            end
        endcase
    end

    // State, running status and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mrstq_pkg::ST_IDLE;
            last_status_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_status_reg <= last_status_next;
            done_reg        <= done_next;
        end
    end

    // Command payload capture and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg      <= status_byte;
            d1_reg      <= first_data;
            d2_reg      <= second_data;
            usb_ok_reg  <= usb_ready;
            uart_ok_reg <= uart_ready;
        end
        usb_valid_reg    <= usb_valid_next;
        usb_header_reg   <= usb_header_next;
        usb_status_reg   <= usb_status_next;
        usb_d1_reg       <= usb_d1_next;
        usb_d2_reg       <= usb_d2_next;
        serial_valid_reg <= serial_valid_next;
        serial_byte_reg  <= serial_byte_next;
    end

    assign busy         = (state_reg != mrstq_pkg::ST_IDLE);
    assign done         = done_reg;
    assign usb_valid    = usb_valid_reg;
    assign usb_header   = usb_header_reg;
    assign usb_status   = usb_status_reg;
    assign usb_data_one = usb_d1_reg;
    assign usb_data_two = usb_d2_reg;
    assign serial_valid = serial_valid_reg;
    assign serial_byte  = serial_byte_reg;

endmodule

/* sv/mrstq_ring.sv */
// ----------------------------------------------------------------------------
// MIDI running-status transmit queue: ring buffer
// Synchronous memory with wrapping write and read indices; the read data is
// registered, so a fetch returns its entry in the following cycle. Overrun is silent.
// ----------------------------------------------------------------------------
module mrstq_ring #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mrstq_pkg::ring_ctrl_t    ctrl,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data,
    output logic                     not_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]    wr_idx_reg;
    logic [AW-1:0]    wr_idx_next;
    logic [AW-1:0]    rd_idx_reg;
    logic [AW-1:0]    rd_idx_next;

    // Index advance with wrap at the configured depth.
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        if (ctrl.push)
        begin
            wr_idx_next = (wr_idx_reg == AW'(DEPTH - 1)) ? '0 : wr_idx_reg + AW'(1);
        end
        if (ctrl.pop)
        begin
            rd_idx_next = (rd_idx_reg == AW'(DEPTH - 1)) ? '0 : rd_idx_reg + AW'(1);
        end
    end

    // Index registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Memory write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_idx_reg] <= wr_data;
        end
        if (ctrl.fetch)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    assign rd_data   = rd_data_reg;
    assign not_empty = (rd_idx_reg != wr_idx_reg);

endmodule
